// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Every check is clocked on the rising edge and is off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every edge once reset is released.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== rtl/pruc_pkg.sv =====
`default_nettype none

package pruc_pkg;

    // datapath widths
    localparam int MW = 32;             // modulus / element width
    localparam int OW = 16;             // order width
    localparam int CW = $clog2(MW);     // bit counter of the mod-MAC

    // register map (index = paddr[2])
    localparam logic REG_MODULUS = 1'b0;
    localparam logic REG_ORDER   = 1'b1;

    localparam logic [MW-1:0] MODULUS_RST = MW'(12289);
    localparam logic [OW-1:0] ORDER_RST   = OW'(512);

    // sequencer program counter
    typedef logic [3:0] t_pc;

    localparam t_pc PC_WAIT = 4'd0;
    localparam t_pc PC_CHKQ = 4'd1;
    localparam t_pc PC_CHKN = 4'd2;
    localparam t_pc PC_RED  = 4'd3;
    localparam t_pc PC_TEST = 4'd4;
    localparam t_pc PC_CHKR = 4'd5;
    localparam t_pc PC_MUL  = 4'd6;
    localparam t_pc PC_HIT  = 4'd7;
    localparam t_pc PC_FAIL = 4'd8;
    localparam t_pc PC_PASS = 4'd9;
    localparam t_pc PC_EMIT = 4'd10;

    // jump conditions
    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_Q_LT2,
        COND_N_ZERO,
        COND_P_ONE,
        COND_R_EQ_N
    } t_cond;

    // mod-MAC operation: acc = a * b mod m, bit-serial over b
    typedef enum logic [1:0] {
        MAC_NONE,
        MAC_RED,    // a=1, b=candidate, m=modulus
        MAC_MUL,    // a=x, b=p, m=modulus
        MAC_DIV     // a=1, b=order, m=r
    } t_mac;

    // writeback at the end of a step
    typedef enum logic [2:0] {
        WB_NONE,
        WB_XP,
        WB_P,
        WB_FLAGS,
        WB_FAIL,
        WB_PASS
    } t_wb;

    typedef struct packed {
        logic  take;
        logic  emit;
        t_mac  mac;
        t_wb   wb;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // control store
    function automatic t_uword ucode(input t_pc pc);
        t_uword uw;
        unique case (pc)
            PC_WAIT: uw = '{1'b1, 1'b0, MAC_NONE, WB_NONE,  COND_NONE,   PC_WAIT};
            PC_CHKQ: uw = '{1'b0, 1'b0, MAC_NONE, WB_NONE,  COND_Q_LT2,  PC_FAIL};
            PC_CHKN: uw = '{1'b0, 1'b0, MAC_NONE, WB_NONE,  COND_N_ZERO, PC_PASS};
            PC_RED:  uw = '{1'b0, 1'b0, MAC_RED,  WB_XP,    COND_NONE,   PC_WAIT};
            PC_TEST: uw = '{1'b0, 1'b0, MAC_NONE, WB_NONE,  COND_P_ONE,  PC_HIT};
            PC_CHKR: uw = '{1'b0, 1'b0, MAC_NONE, WB_NONE,  COND_R_EQ_N, PC_FAIL};
            PC_MUL:  uw = '{1'b0, 1'b0, MAC_MUL,  WB_P,     COND_ALWAYS, PC_TEST};
            PC_HIT:  uw = '{1'b0, 1'b0, MAC_DIV,  WB_FLAGS, COND_ALWAYS, PC_EMIT};
            PC_FAIL: uw = '{1'b0, 1'b0, MAC_NONE, WB_FAIL,  COND_ALWAYS, PC_EMIT};
            PC_PASS: uw = '{1'b0, 1'b0, MAC_NONE, WB_PASS,  COND_NONE,   PC_WAIT};
            PC_EMIT: uw = '{1'b0, 1'b1, MAC_NONE, WB_NONE,  COND_ALWAYS, PC_WAIT};
            default: uw = '{1'b0, 1'b0, MAC_NONE, WB_NONE,  COND_ALWAYS, PC_WAIT};
        endcase
        return uw;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pruc_modmac.sv =====
`default_nettype none

// Bit-serial modular multiply-accumulate: acc = a * b mod m, MSB of b first.
// Needs a < m (or m = 1). One bit per cycle; done pulses once the last bit is in.
module pruc_modmac
    import pruc_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [MW-1:0] i_a,
    input  wire logic [MW-1:0] i_b,
    input  wire logic [MW-1:0] i_m,
    output logic               o_done,
    output logic [MW-1:0]      o_acc
);

    logic [MW-1:0] r_acc;
    logic [MW-1:0] r_a;
    logic [MW-1:0] r_b;
    logic [MW-1:0] r_m;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [MW+1:0] sum;
    logic [MW+1:0] m1;
    logic [MW+1:0] m2;
    logic [MW-1:0] n_acc;

    // sum = 2*acc + bit*a < 3m, so at most two subtractions of m
    always_comb begin
        sum = {1'b0, r_acc, 1'b0} + (r_b[MW-1] ? {2'b00, r_a} : '0);
        m1  = {2'b00, r_m};
        m2  = {1'b0, r_m, 1'b0};
        if (sum >= m2) begin
            n_acc = MW'(sum - m2);
        end else if (sum >= m1) begin
            n_acc = MW'(sum - m1);
        end else begin
            n_acc = MW'(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CW'(MW - 1));
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CW'(MW - 1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
            r_m   <= i_m;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[MW-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

`default_nettype wire

// ===== rtl/primitive_root_of_unity_check.sv =====
`default_nettype none

// Primitive n-th root of unity test modulo q. Each item is one 32-bit
// candidate x; the block reduces it modulo the modulus register q and walks
// the powers x, x^2, ... until the first power r that equals 1 or until r
// reaches the order register n. One result item per candidate: is_root is
// set when x^n = 1 mod q (the first hit r divides n) and is_primitive when
// that first hit is r = n. A modulus below 2 gives 0/0, an order of 0 gives
// 1/1. The user must write both registers over the APB port only while the
// block is idle (modulus at 0x0, order at 0x4); the block itself does not
// enforce this. Both are read back at the same addresses. All modular
// arithmetic runs on one bit-serial modular multiply unit; each operation
// is a start, 32 bit steps and a done. Each power walked takes a test, an
// exponent check and a multiply. An item runs through the modulus and order
// checks, the reduction of the candidate, the walk and, when a power equals
// 1, the final order-mod-r divisibility test; a modulus below 2 or an order
// of 0 ends it before the reduction. Items are processed one at a time; the
// next item is taken as soon as the result is in the output register, even
// while that result still waits on i_ready. The output load stalls only
// while the previous result waits.
module primitive_root_of_unity_check
    import pruc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // candidate channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_candidate,
    // result channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_is_root,
    output logic             o_is_primitive,
    // APB register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    `include "assert_macros.svh"

    // configuration registers
    logic [MW-1:0] r_modulus;
    logic [OW-1:0] r_order;

    // sequencer
    t_pc    r_pc;
    logic   r_mac_wait;     // mod-MAC launched for the current step
    t_uword uw;
    logic   cond_hit;
    logic   hold;
    logic   go;
    logic   mac_start;

    // working registers
    logic [MW-1:0] r_cand;
    logic [MW-1:0] r_x;     // reduced candidate
    logic [MW-1:0] r_p;     // current power x^r
    logic [OW-1:0] r_r;     // current exponent
    logic          r_root;
    logic          r_prim;

    // output register
    logic r_out_valid;
    logic r_is_root;
    logic r_is_prim;

    // mod-MAC operands
    logic [MW-1:0] mac_a;
    logic [MW-1:0] mac_b;
    logic [MW-1:0] mac_m;
    logic          mac_done;
    logic [MW-1:0] mac_acc;

    logic cfg_wr;

    //--------------------------------------------------------------------
    // APB
    //--------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_ORDER) ? 32'(r_order) : 32'(r_modulus);

    //--------------------------------------------------------------------
    // Control word decode
    //--------------------------------------------------------------------
    assign uw = ucode(r_pc);

    always_comb begin
        unique case (uw.cond)
            COND_NONE:   cond_hit = 1'b0;
            COND_ALWAYS: cond_hit = 1'b1;
            COND_Q_LT2:  cond_hit = (r_modulus < MW'(2));
            COND_N_ZERO: cond_hit = (r_order == '0);
            COND_P_ONE:  cond_hit = (r_p == MW'(1));
            COND_R_EQ_N: cond_hit = (r_r == r_order);
            default:     cond_hit = 1'b1;
        endcase
    end

    // a step stalls on a missing input, a running multiply, or a full
    // output register whose result i_ready does not take
    assign mac_start = (uw.mac != MAC_NONE) && !r_mac_wait;
    assign hold = (uw.take && !i_valid)
               || ((uw.mac != MAC_NONE) && !mac_done)
               || (uw.emit && r_out_valid && !i_ready);
    assign go = !hold;

    assign o_ready = uw.take;

    always_comb begin
        unique case (uw.mac)
            MAC_MUL: begin
                mac_a = r_x;
                mac_b = r_p;
                mac_m = r_modulus;
            end
            MAC_DIV: begin
                // order mod r: zero means r divides the order
                mac_a = MW'(1);
                mac_b = MW'(r_order);
                mac_m = MW'(r_r);
            end
            default: begin
                // candidate mod q
                mac_a = MW'(1);
                mac_b = r_cand;
                mac_m = r_modulus;
            end
        endcase
    end

    pruc_modmac u_modmac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mac_start),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .i_m     (mac_m),
        .o_done  (mac_done),
        .o_acc   (mac_acc)
    );

    //--------------------------------------------------------------------
    // Control state
    //--------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus   <= MODULUS_RST;
            r_order     <= ORDER_RST;
            r_pc        <= PC_WAIT;
            r_mac_wait  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == REG_ORDER) begin
                    r_order <= OW'(pwdata);
                end else begin
                    r_modulus <= MW'(pwdata);
                end
            end
            // a new load wins over the take of the old result
            if (go && uw.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (mac_start) begin
                r_mac_wait <= 1'b1;
            end else if (go) begin
                r_mac_wait <= 1'b0;
            end
            if (go) begin
                r_pc <= cond_hit ? uw.target : r_pc + 1'b1;
            end
        end
    end

    //--------------------------------------------------------------------
    // Datapath writeback
    //--------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (go) begin
            if (uw.take) begin
                r_cand <= MW'(i_candidate);
            end
            if (uw.emit) begin
                r_is_root <= r_root;
                r_is_prim <= r_prim;
            end
            case (uw.wb)
                WB_XP: begin
                    r_x <= mac_acc;
                    r_p <= mac_acc;
                    r_r <= OW'(1);
                end
                WB_P: begin
                    r_p <= mac_acc;
                    r_r <= r_r + 1'b1;
                end
                WB_FLAGS: begin
                    r_root <= (mac_acc == '0);
                    r_prim <= (r_r == r_order);
                end
                WB_FAIL: begin
                    r_root <= 1'b0;
                    r_prim <= 1'b0;
                end
                WB_PASS: begin
                    r_root <= 1'b1;
                    r_prim <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_is_root      = r_is_root;
    assign o_is_primitive = r_is_prim;

    //--------------------------------------------------------------------
    // Checks
    //--------------------------------------------------------------------
    // the multiply unit only finishes for a step that launched it
    `ASSERT_AT(a_done_owned, i_clk, i_rst_n, mac_done |-> r_mac_wait, "mod-MAC done unexpected")
    // every walked power is fully reduced
    `ASSERT_AT(a_p_reduced, i_clk, i_rst_n, (r_pc == PC_TEST) |-> (r_p < r_modulus), "power not reduced")
    // exponent stays within 1..order during the walk
    `ASSERT_NEVER(a_r_range, i_clk, i_rst_n, (r_pc == PC_TEST) && ((r_r == '0) || (r_r > r_order)), "exponent out of range")
    // an accepted item always starts at the modulus check
    `ASSERT_AT(a_accept_seq, i_clk, i_rst_n, (i_valid && o_ready) |=> (r_pc == PC_CHKQ), "bad start after accept")

endmodule

`default_nettype wire
